// ===== rtl/mbd_pkg.sv =====
// Package for the multi-button debouncer: field widths, limits, the
// per-button phase encoding and the per-button state record.
// No dependencies.
`default_nettype none

package mbd_pkg;

   localparam int NUM_BUTTONS_DEF = 4;

   localparam int ID_W    = 2;
   localparam int PHASE_W = 2;
   localparam int COUNT_W = 9;
   localparam int HOLD_W  = 8;
   localparam int POLLS_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
   localparam logic [HOLD_W-1:0]  HOLD_MAX  = 8'd255;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_UP       = 2'd0,
      PHASE_PUSHED   = 2'd1,
      PHASE_DOWN     = 2'd2,
      PHASE_RELEASED = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [COUNT_W-1:0] debounce_count;
      logic [HOLD_W-1:0]  hold_tally;
   } button_entry_type;

   localparam button_entry_type ENTRY_RESET = '{
      phase:          PHASE_UP,
      debounce_count: '0,
      hold_tally:     '0
   };

endpackage

`default_nettype wire

// ===== rtl/mbd_button_fsm.sv =====
// Next-state logic of one button: phase machine, debounce and hold counters.
// Depends on mbd_pkg.
`default_nettype none

module mbd_button_fsm
   import mbd_pkg::*;
(
   input  button_entry_type   cur_entry,
   input  logic               pressed,
   input  logic [POLLS_W-1:0] debounce_polls,
   output button_entry_type   nxt_entry
);

   logic [COUNT_W-1:0] count_inc;
   logic [HOLD_W-1:0]  hold_inc;
   logic               count_over;

   assign count_inc  = (cur_entry.debounce_count >= COUNT_MAX) ? COUNT_MAX
                     : cur_entry.debounce_count + COUNT_W'(1);
   assign hold_inc   = (cur_entry.hold_tally == HOLD_MAX) ? HOLD_MAX
                     : cur_entry.hold_tally + HOLD_W'(1);
   assign count_over = count_inc > COUNT_W'(debounce_polls);

   always_comb begin
      nxt_entry = cur_entry;
      case (cur_entry.phase)
         PHASE_UP: begin
            if (pressed) begin
               nxt_entry.debounce_count = count_inc;
               if (count_over) begin
                  nxt_entry.phase = PHASE_PUSHED;
               end
            end else begin
               nxt_entry.debounce_count = '0;
            end
         end
         PHASE_PUSHED: begin
            nxt_entry.hold_tally = '0;
            nxt_entry.phase      = PHASE_DOWN;
         end
         PHASE_DOWN: begin
            if (pressed) begin
               nxt_entry.hold_tally     = hold_inc;
               nxt_entry.debounce_count = '0;
            end else begin
               nxt_entry.debounce_count = count_inc;
               if (count_over) begin
                  nxt_entry.phase = PHASE_RELEASED;
               end
            end
         end
         default: begin
            nxt_entry.phase = PHASE_UP;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/mbd_state_file.sv =====
// Per-button state registers with one read port and one write port.
// Depends on mbd_pkg.
`default_nettype none

module mbd_state_file
   import mbd_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int SLOT_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_slot,
   output button_entry_type  rd_entry,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  button_entry_type  wr_entry
);

   button_entry_type entry_ff [NUM_BUTTONS];

   assign rd_entry = (int'(rd_slot) < NUM_BUTTONS) ? entry_ff[rd_slot] : ENTRY_RESET;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            entry_ff[i] <= ENTRY_RESET;
         end
      end else if (wr_en) begin
         entry_ff[wr_slot] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/multi_button_debouncer.sv =====
// Top level of the multi-button debouncer: poll input register, state file,
// button update logic and result register. Depends on mbd_pkg,
// mbd_state_file and mbd_button_fsm.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | button_index, pressed
//   rsp     | out       | rsp_valid/stall    | button_id, debounced_state, hold_polls
//   csr     | in        | csr_valid/ready    | debounce_polls
//
// One poll beat per cycle unless rsp stalls; beats pass input, then result register.
// The state read-modify-write sits between the input and result registers,
// so consecutive beats on the same button see each other's updates.
// Reset clears all button states and debounce_polls.
// A stall on rsp holds the result; req stalls only when both registers are full.
`default_nettype none

module multi_button_debouncer
   import mbd_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ID_W-1:0]    req_button_index,
   input  logic               req_pressed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_W-1:0]    rsp_button_id,
   output logic [PHASE_W-1:0] rsp_debounced_state,
   output logic [HOLD_W-1:0]  rsp_hold_polls,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [POLLS_W-1:0] csr_debounce_polls
);

   localparam int SLOT_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   logic [POLLS_W-1:0] debounce_polls_ff;

   logic               in_valid_ff, in_valid_in;
   logic [ID_W-1:0]    in_index_ff;
   logic               in_pressed_ff;

   logic               out_valid_ff, out_valid_in;
   logic [ID_W-1:0]    out_id_ff;
   logic [PHASE_W-1:0] out_state_ff;
   logic [HOLD_W-1:0]  out_hold_ff;

   logic               in_load;
   logic               out_load;
   logic               slot_ok;
   logic [SLOT_W-1:0]  slot;
   button_entry_type   cur_entry;
   button_entry_type   nxt_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_polls_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         debounce_polls_ff <= csr_debounce_polls;
      end
   end

   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_index_ff   <= req_button_index;
         in_pressed_ff <= req_pressed;
      end
   end

   assign slot_ok = int'(in_index_ff) < NUM_BUTTONS;
   assign slot    = SLOT_W'(in_index_ff);

   mbd_state_file #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .SLOT_W      (SLOT_W)
   ) u_state_file (
      .clock    (clock),
      .reset    (reset),
      .rd_slot  (slot),
      .rd_entry (cur_entry),
      .wr_en    (out_load && slot_ok),
      .wr_slot  (slot),
      .wr_entry (nxt_entry)
   );

   mbd_button_fsm u_button_fsm (
      .cur_entry      (cur_entry),
      .pressed        (in_pressed_ff),
      .debounce_polls (debounce_polls_ff),
      .nxt_entry      (nxt_entry)
   );

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_id_ff    <= in_index_ff;
         out_state_ff <= slot_ok ? PHASE_W'(nxt_entry.phase) : '0;
         out_hold_ff  <= slot_ok ? nxt_entry.hold_tally : '0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_button_id       = out_id_ff;
   assign rsp_debounced_state = out_state_ff;
   assign rsp_hold_polls      = out_hold_ff;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for multi_button_debouncer: drives poll beats and debounce settings,
// predicts each button's phase and hold count, and checks every result beat.
// Depends on mbd_pkg and the multi_button_debouncer RTL.
`timescale 1ns / 1ps

module tb;
   import mbd_pkg::*;

   localparam int LIMIT_CYCLES = 300000;

   typedef struct packed {
      logic [ID_W-1:0]   button_id;
      phase_type         state;
      logic [HOLD_W-1:0] hold;
   } poll_result_type;

   class button_tracker;
      phase_type          phase [NUM_BUTTONS_DEF];
      logic [COUNT_W-1:0] debounce [NUM_BUTTONS_DEF];
      logic [HOLD_W-1:0]  hold [NUM_BUTTONS_DEF];
      logic [POLLS_W-1:0] debounce_limit;
      poll_result_type    awaited_results[$];
      int                 errors;

      function new();
         debounce_limit = '0;
         errors = 0;
         for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
            phase[i] = PHASE_UP;
            debounce[i] = '0;
            hold[i] = '0;
         end
      endfunction

      function logic [COUNT_W-1:0] count_step(logic [COUNT_W-1:0] c);
         return (c >= COUNT_MAX) ? COUNT_MAX : c + 1'b1;
      endfunction

      function void note_poll(logic [ID_W-1:0] idx, logic pressed);
         poll_result_type r;
         phase_type       ph;
         r.button_id = idx;
         r.state = PHASE_UP;
         r.hold = '0;
         if (int'(idx) < NUM_BUTTONS_DEF) begin
            ph = phase[idx];
            case (ph)
               PHASE_UP: begin
                  if (pressed) begin
                     debounce[idx] = count_step(debounce[idx]);
                     if (debounce[idx] > debounce_limit) ph = PHASE_PUSHED;
                  end else begin
                     debounce[idx] = '0;
                  end
               end
               PHASE_PUSHED: begin
                  hold[idx] = '0;
                  ph = PHASE_DOWN;
               end
               PHASE_DOWN: begin
                  if (pressed) begin
                     if (hold[idx] != HOLD_MAX) hold[idx] = hold[idx] + 1'b1;
                     debounce[idx] = '0;
                  end else begin
                     debounce[idx] = count_step(debounce[idx]);
                     if (debounce[idx] > debounce_limit) ph = PHASE_RELEASED;
                  end
               end
               default: begin
                  ph = PHASE_UP;
               end
            endcase
            phase[idx] = ph;
            r.state = ph;
            r.hold = hold[idx];
         end
         awaited_results.push_back(r);
      endfunction

      function void check_result(logic [ID_W-1:0] id, logic [PHASE_W-1:0] state,
                                 logic [HOLD_W-1:0] held);
         poll_result_type e;
         if (awaited_results.size() == 0) begin
            $display("%0t: result beat with no poll pending: id %0d state %0d hold %0d",
                     $time, id, state, held);
            errors++;
            return;
         end
         e = awaited_results.pop_front();
         if (id !== e.button_id) begin
            $display("%0t: button_id mismatch: expected %0d, actual %0d",
                     $time, e.button_id, id);
            errors++;
         end
         if (state !== e.state) begin
            $display("%0t: debounced_state mismatch on button %0d: expected %0d, actual %0d",
                     $time, e.button_id, e.state, state);
            errors++;
         end
         if (held !== e.hold) begin
            $display("%0t: hold_polls mismatch on button %0d: expected %0d, actual %0d",
                     $time, e.button_id, e.hold, held);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [ID_W-1:0]    req_button_index = '0;
   logic               req_pressed = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [ID_W-1:0]    rsp_button_id;
   logic [PHASE_W-1:0] rsp_debounced_state;
   logic [HOLD_W-1:0]  rsp_hold_polls;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [POLLS_W-1:0] csr_debounce_polls = '0;

   button_tracker tracker = new();
   bit            idling_on = 1'b0;
   int            stall_left = 0;
   int            cycle_count = 0;
   logic          target_level [NUM_BUTTONS_DEF] = '{default: 1'b0};
   int            run_left [NUM_BUTTONS_DEF] = '{default: 0};

   logic [2:0] directed_polls [22] = '{
      3'b000, 3'b001, 3'b000, 3'b001, 3'b001, 3'b000, 3'b001, 3'b000,
      3'b011, 3'b011, 3'b010, 3'b010,
      3'b101, 3'b101, 3'b101, 3'b100, 3'b100, 3'b100,
      3'b111, 3'b111, 3'b110, 3'b111
   };

   multi_button_debouncer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_button_index    (req_button_index),
      .req_pressed         (req_pressed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_button_id       (rsp_button_id),
      .rsp_debounced_state (rsp_debounced_state),
      .rsp_hold_polls      (rsp_hold_polls),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_debounce_polls  (csr_debounce_polls)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.note_poll(req_button_index, req_pressed);
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_result(rsp_button_id, rsp_debounced_state, rsp_hold_polls);
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_poll(input logic [ID_W-1:0] idx, input logic p);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_button_index <= idx;
      req_pressed <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_polls();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_polls(input logic [POLLS_W-1:0] limit);
      drain_polls();
      csr_valid <= 1'b1;
      csr_debounce_polls <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.debounce_limit = limit;
   endtask

   // Mostly runs just long enough to cross the debounce limit, some short runs and flips.
   task automatic run_random(input int count);
      int   idx;
      int   lim;
      logic p;
      for (int n = 0; n < count; n++) begin
         idx = $urandom_range(0, NUM_BUTTONS_DEF - 1);
         lim = int'(tracker.debounce_limit);
         if (run_left[idx] == 0) begin
            target_level[idx] = ~target_level[idx];
            if ($urandom_range(0, 4) == 0) run_left[idx] = $urandom_range(1, lim + 1);
            else run_left[idx] = $urandom_range(lim + 1, lim + 6);
         end
         run_left[idx]--;
         p = target_level[idx];
         if ($urandom_range(0, 19) == 0) p = ~p;
         send_poll(idx[ID_W-1:0], p);
      end
   endtask

   // Hold one button at a level, with stray beats on the others mixed in.
   task automatic hold_button(input logic [ID_W-1:0] idx, input logic p, input int polls);
      logic [ID_W-1:0] other;
      int              n;
      n = 0;
      while (n < polls) begin
         if ($urandom_range(0, 7) == 0) begin
            other = ID_W'($urandom_range(0, NUM_BUTTONS_DEF - 1));
            if (other != idx) send_poll(other, 1'($urandom_range(0, 1)));
         end else begin
            send_poll(idx, p);
            n++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;
      write_polls(8'd0);
      foreach (directed_polls[i]) send_poll(directed_polls[i][2:1], directed_polls[i][0]);
      write_polls(8'd1);
      run_random(250);
      write_polls(8'd255);
      hold_button(2'd3, 1'b1, 258);
      hold_button(2'd3, 1'b0, 258);
      write_polls(8'd0);
      idling_on = 1'b0;
      hold_button(2'd1, 1'b1, 262);
      idling_on = 1'b1;
      hold_button(2'd1, 1'b0, 4);
      write_polls(POLLS_W'($urandom_range(2, 8)));
      idling_on = 1'b0;
      run_random(300);
      drain_polls();
      if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
